// ----- rtl/qte_pkg.sv -----
`default_nettype none
package qte_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_LEN = 24;
   localparam int QUEUE_DEPTH = 4;
   localparam int DIV_BITS = 31;
   localparam int SQRT_BITS = 31;
   localparam int CORDIC_W = 36;
   localparam int ANGLE_W = 32;

   localparam logic signed [ANGLE_W-1:0] HALF_PI_Q29 = 32'sd843314857;
   localparam logic [22:0] RAD2DEG_Q16 = 23'd3754936;
   localparam logic signed [17:0] RAD_MAX_PI = 18'sd25736;
   localparam logic signed [17:0] RAD_MAX_HALF = 18'sd12868;
   localparam logic signed [17:0] DEG_MAX_PI = 18'sd23040;
   localparam logic signed [17:0] DEG_MAX_HALF = 18'sd11520;

   // one classified quaternion, as it waits between front and back
   typedef struct packed {
      logic [32:0] n;
      logic [32:0] mag;
      logic s_neg;
      logic zero;
      logic clamp;
      logic signed [32:0] yaw_x;
      logic signed [33:0] yaw_y;
      logic signed [32:0] roll_x;
      logic signed [33:0] roll_y;
   } qte_work_type;

   typedef struct packed {
      logic valid;
      qte_work_type work;
   } qte_push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qte_q_status_type;

   // round(atan(2^-i) * 2^29)
   function automatic logic signed [ANGLE_W-1:0] qte_atan(input logic [4:0] idx);
      logic signed [ANGLE_W-1:0] v;
      unique case (idx)
         5'd0: v = 32'sd421657428;
         5'd1: v = 32'sd248918915;
         5'd2: v = 32'sd131521918;
         5'd3: v = 32'sd66762579;
         5'd4: v = 32'sd33510843;
         5'd5: v = 32'sd16771758;
         5'd6: v = 32'sd8387925;
         5'd7: v = 32'sd4194219;
         5'd8: v = 32'sd2097141;
         5'd9: v = 32'sd1048575;
         5'd10: v = 32'sd524288;
         5'd11: v = 32'sd262144;
         5'd12: v = 32'sd131072;
         5'd13: v = 32'sd65536;
         5'd14: v = 32'sd32768;
         5'd15: v = 32'sd16384;
         5'd16: v = 32'sd8192;
         5'd17: v = 32'sd4096;
         5'd18: v = 32'sd2048;
         5'd19: v = 32'sd1024;
         5'd20: v = 32'sd512;
         5'd21: v = 32'sd256;
         5'd22: v = 32'sd128;
         5'd23: v = 32'sd64;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic signed [15:0] qte_saturate(input logic signed [17:0] r,
                                                       input logic signed [17:0] lim);
      logic signed [17:0] v;
      v = r;
      if (r > lim) begin
         v = lim;
      end else if (r < -lim) begin
         v = -lim;
      end
      return v[15:0];
   endfunction

endpackage
`default_nettype wire

// ----- rtl/qte_channels_if.sv -----
`default_nettype none
interface qte_req_if;
   logic valid;
   logic ready;
   logic signed [15:0] quat_real;
   logic signed [15:0] quat_i;
   logic signed [15:0] quat_j;
   logic signed [15:0] quat_k;
   modport source(output valid, quat_real, quat_i, quat_j, quat_k, input ready);
   modport sink(input valid, quat_real, quat_i, quat_j, quat_k, output ready);
endinterface

interface qte_rsp_if;
   logic valid;
   logic ready;
   logic signed [15:0] yaw_angle;
   logic signed [14:0] pitch_angle;
   logic signed [15:0] roll_angle;
   logic range_error;
   modport source(output valid, yaw_angle, pitch_angle, roll_angle, range_error,
                  input ready);
   modport sink(input valid, yaw_angle, pitch_angle, roll_angle, range_error,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/qte_front.sv -----
`default_nettype none
module qte_front
   import qte_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   qte_req_if.sink          req_ch,
   input  qte_q_status_type q_stat,
   output qte_push_type     push
);

   logic advance;
   logic a_v_ff, b_v_ff;
   logic signed [31:0] p_ww_ff, p_xx_ff, p_yy_ff, p_zz_ff;
   logic signed [31:0] p_yw_ff, p_xz_ff, p_xy_ff, p_zw_ff, p_yz_ff, p_xw_ff;
   qte_work_type work_in, work_ff;

   logic signed [33:0] sw, sx, sy, sz, n_s, s_val, mag_s, yx_s, rx_s;

   assign advance = !b_v_ff || !q_stat.full;
   assign req_ch.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
      end else if (advance) begin
         a_v_ff <= req_ch.valid;
         b_v_ff <= a_v_ff;
      end
   end

   // squares and cross products
   always_ff @(posedge clock) begin
      if (advance) begin
         p_ww_ff <= 32'(req_ch.quat_real) * 32'(req_ch.quat_real);
         p_xx_ff <= 32'(req_ch.quat_i) * 32'(req_ch.quat_i);
         p_yy_ff <= 32'(req_ch.quat_j) * 32'(req_ch.quat_j);
         p_zz_ff <= 32'(req_ch.quat_k) * 32'(req_ch.quat_k);
         p_yw_ff <= 32'(req_ch.quat_j) * 32'(req_ch.quat_real);
         p_xz_ff <= 32'(req_ch.quat_i) * 32'(req_ch.quat_k);
         p_xy_ff <= 32'(req_ch.quat_i) * 32'(req_ch.quat_j);
         p_zw_ff <= 32'(req_ch.quat_k) * 32'(req_ch.quat_real);
         p_yz_ff <= 32'(req_ch.quat_j) * 32'(req_ch.quat_k);
         p_xw_ff <= 32'(req_ch.quat_i) * 32'(req_ch.quat_real);
      end
   end

   always_comb begin
      sw = 34'(p_ww_ff);
      sx = 34'(p_xx_ff);
      sy = 34'(p_yy_ff);
      sz = 34'(p_zz_ff);
      n_s = sw + sx + sy + sz;
      s_val = (34'(p_yw_ff) - 34'(p_xz_ff)) <<< 1;
      mag_s = s_val[33] ? -s_val : s_val;
      yx_s = sw + sx - sy - sz;
      rx_s = sw - sx - sy + sz;

      work_in.n = n_s[32:0];
      work_in.s_neg = s_val[33];
      work_in.zero = (n_s == '0);
      work_in.clamp = !work_in.zero && (mag_s[32:0] > n_s[32:0]);
      // a clamped argument divides n by itself, giving exactly one
      work_in.mag = work_in.clamp ? n_s[32:0] : mag_s[32:0];
      work_in.yaw_x = yx_s[32:0];
      work_in.yaw_y = (34'(p_xy_ff) + 34'(p_zw_ff)) <<< 1;
      work_in.roll_x = rx_s[32:0];
      work_in.roll_y = (34'(p_yz_ff) + 34'(p_xw_ff)) <<< 1;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         work_ff <= work_in;
      end
   end

   assign push.valid = b_v_ff && advance;
   assign push.work = work_ff;

endmodule
`default_nettype wire

// ----- rtl/qte_queue.sv -----
`default_nettype none
module qte_queue
   import qte_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  qte_push_type     push,
   input  logic             pop,
   output qte_work_type     head,
   output qte_q_status_type stat
);

   localparam int AW = $clog2(QUEUE_DEPTH);

   qte_work_type slot_ff [0:QUEUE_DEPTH-1];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0] cnt_ff;

   assign stat.full = (cnt_ff == (AW+1)'(QUEUE_DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign head = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ff] <= push.work;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push.valid) begin
            wr_ff <= (wr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + (AW+1)'(push.valid) - (AW+1)'(pop);
      end
   end

endmodule
`default_nettype wire

// ----- rtl/qte_cordic.sv -----
`default_nettype none
module qte_cordic
   import qte_pkg::*;
#(
   parameter int STEPS = CORDIC_STEPS_DEF
)
(
   input  logic                        clock,
   input  logic                        en,
   input  logic signed [CORDIC_W-1:0]  vec_x,
   input  logic signed [CORDIC_W-1:0]  vec_y,
   output logic signed [ANGLE_W-1:0]   angle
);

   logic signed [CORDIC_W-1:0] x_ff [0:STEPS];
   logic signed [CORDIC_W-1:0] y_ff [0:STEPS];
   logic signed [ANGLE_W-1:0] z_ff [0:STEPS];
   logic zr_ff [0:STEPS];
   logic signed [CORDIC_W-1:0] x_in, y_in;
   logic signed [ANGLE_W-1:0] z_in;

   // left half plane is turned by a quarter first
   always_comb begin
      x_in = vec_x;
      y_in = vec_y;
      z_in = '0;
      if (vec_x[CORDIC_W-1]) begin
         if (!vec_y[CORDIC_W-1]) begin
            x_in = vec_y;
            y_in = -vec_x;
            z_in = HALF_PI_Q29;
         end else begin
            x_in = -vec_y;
            y_in = vec_x;
            z_in = -HALF_PI_Q29;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= x_in;
         y_ff[0] <= y_in;
         z_ff[0] <= z_in;
         zr_ff[0] <= (vec_x == '0) && (vec_y == '0);
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic signed [CORDIC_W-1:0] dx, dy;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (en) begin
            zr_ff[i+1] <= zr_ff[i];
            if (!y_ff[i][CORDIC_W-1]) begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + qte_atan(5'(i));
            end else begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - qte_atan(5'(i));
            end
         end
      end
   end

   // a zero vector has angle zero
   assign angle = zr_ff[STEPS] ? '0 : z_ff[STEPS];

endmodule
`default_nettype wire

// ----- rtl/qte_back.sv -----
`default_nettype none
module qte_back
   import qte_pkg::*;
#(
   parameter int STEPS = CORDIC_STEPS_DEF
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             angle_in_degrees,
   input  qte_q_status_type q_stat,
   input  qte_work_type     q_head,
   output logic             pop,
   qte_rsp_if.source        rsp_ch
);

   localparam int SQ_FIRST = DIV_BITS + 1;
   localparam int SQ_LAST = SQ_FIRST + SQRT_BITS;
   localparam int LAST = SQ_LAST + STEPS + 2;

   logic adv;
   logic [LAST:0] vld_ff;
   qte_work_type side_ff [0:LAST];
   logic rsp_v_ff;

   assign adv = !rsp_v_ff || rsp_ch.ready;
   assign pop = adv && !q_stat.empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAST-1:0], pop};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= q_head;
         for (int p = 1; p <= LAST; p++) begin
            side_ff[p] <= side_ff[p-1];
         end
      end
   end

   // restoring divider, one quotient bit a stage
   logic [33:0] dv_rem_ff [0:DIV_BITS-1];
   logic [DIV_BITS-1:0] dv_q_ff [0:DIV_BITS];

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_rem_ff[0] <= 34'(q_head.mag);
         dv_q_ff[0] <= '0;
      end
   end

   for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
      logic [33:0] shifted, rem_in;
      logic bit_in;
      if (j == 0) begin : g_first
         assign shifted = dv_rem_ff[j];
      end else begin : g_next
         assign shifted = dv_rem_ff[j] << 1;
      end
      assign bit_in = shifted >= 34'(side_ff[j].n);
      assign rem_in = bit_in ? shifted - 34'(side_ff[j].n) : shifted;
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_q_ff[j+1] <= {dv_q_ff[j][DIV_BITS-2:0], bit_in};
         end
      end
      if (j < DIV_BITS - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (adv) begin
               dv_rem_ff[j+1] <= rem_in;
            end
         end
      end
   end

   // cosine term: floor sqrt of 2^60 - t^2, one root bit a stage
   logic [60:0] sq_rem_ff [0:SQRT_BITS-1];
   logic [SQRT_BITS-1:0] sq_root_ff [0:SQRT_BITS];
   logic [DIV_BITS-1:0] sq_t_ff [0:SQRT_BITS];
   logic [61:0] tt, v_in;

   assign tt = 62'(dv_q_ff[DIV_BITS]) * 62'(dv_q_ff[DIV_BITS]);
   assign v_in = (62'(1) << 60) - tt;

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_rem_ff[0] <= v_in[60:0];
         sq_root_ff[0] <= '0;
         sq_t_ff[0] <= dv_q_ff[DIV_BITS];
      end
   end

   for (genvar m = 0; m < SQRT_BITS; m++) begin : g_sqrt
      localparam int K = SQRT_BITS - 1 - m;
      logic [62:0] delta;
      logic take;
      assign delta = (63'(sq_root_ff[m]) << (K + 1)) + (63'(1) << (2 * K));
      assign take = delta <= 63'(sq_rem_ff[m]);
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_root_ff[m+1] <= take ? (sq_root_ff[m] | (SQRT_BITS'(1) << K))
                                    : sq_root_ff[m];
            sq_t_ff[m+1] <= sq_t_ff[m];
         end
      end
      if (m < SQRT_BITS - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (adv) begin
               sq_rem_ff[m+1] <= take ? sq_rem_ff[m] - delta[60:0] : sq_rem_ff[m];
            end
         end
      end
   end

   // three atan2 units side by side
   logic signed [CORDIC_W-1:0] t_mag, p_y;
   logic signed [ANGLE_W-1:0] z_yaw, z_pitch, z_roll;

   assign t_mag = CORDIC_W'(sq_t_ff[SQRT_BITS]);
   assign p_y = side_ff[SQ_LAST].s_neg ? -t_mag : t_mag;

   qte_cordic #(.STEPS(STEPS)) u_yaw (
      .clock(clock), .en(adv),
      .vec_x(CORDIC_W'(side_ff[SQ_LAST].yaw_x)),
      .vec_y(CORDIC_W'(side_ff[SQ_LAST].yaw_y)),
      .angle(z_yaw)
   );

   qte_cordic #(.STEPS(STEPS)) u_pitch (
      .clock(clock), .en(adv),
      .vec_x(CORDIC_W'(sq_root_ff[SQRT_BITS])),
      .vec_y(p_y),
      .angle(z_pitch)
   );

   qte_cordic #(.STEPS(STEPS)) u_roll (
      .clock(clock), .en(adv),
      .vec_x(CORDIC_W'(side_ff[SQ_LAST].roll_x)),
      .vec_y(CORDIC_W'(side_ff[SQ_LAST].roll_y)),
      .angle(z_roll)
   );

   // unit conversion: degree product first, then round and saturate
   logic signed [ANGLE_W-1:0] cv_z_ff [0:2];
   logic signed [54:0] cv_p_ff [0:2];
   logic signed [ANGLE_W-1:0] z_lane [0:2];
   logic signed [15:0] ang [0:2];

   assign z_lane[0] = z_yaw;
   assign z_lane[1] = z_pitch;
   assign z_lane[2] = z_roll;

   for (genvar l = 0; l < 3; l++) begin : g_conv
      logic signed [54:0] deg_sum;
      logic signed [32:0] rad_sum;
      logic signed [17:0] r;
      logic signed [17:0] lim;
      always_ff @(posedge clock) begin
         if (adv) begin
            cv_z_ff[l] <= z_lane[l];
            cv_p_ff[l] <= 55'(z_lane[l]) * 55'($signed({1'b0, RAD2DEG_Q16}));
         end
      end
      assign deg_sum = cv_p_ff[l] + (55'sd1 <<< 37);
      assign rad_sum = 33'(cv_z_ff[l]) + 33'sd32768;
      always_comb begin
         if (angle_in_degrees) begin
            r = 18'(deg_sum >>> 38);
            lim = (l == 1) ? DEG_MAX_HALF : DEG_MAX_PI;
         end else begin
            r = 18'(rad_sum >>> 16);
            lim = (l == 1) ? RAD_MAX_HALF : RAD_MAX_PI;
         end
      end
      assign ang[l] = qte_saturate(r, lim);
   end

   logic signed [15:0] yaw_ff, roll_ff;
   logic signed [14:0] pitch_ff;
   logic err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         rsp_v_ff <= vld_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (side_ff[LAST].zero) begin
            yaw_ff <= '0;
            pitch_ff <= '0;
            roll_ff <= '0;
         end else begin
            yaw_ff <= ang[0];
            pitch_ff <= ang[1][14:0];
            roll_ff <= ang[2];
         end
         err_ff <= side_ff[LAST].zero || side_ff[LAST].clamp;
      end
   end

   assign rsp_ch.valid = rsp_v_ff;
   assign rsp_ch.yaw_angle = yaw_ff;
   assign rsp_ch.pitch_angle = pitch_ff;
   assign rsp_ch.roll_angle = roll_ff;
   assign rsp_ch.range_error = err_ff;

endmodule
`default_nettype wire

// ----- rtl/quaternion_to_euler_angles_unit.sv -----
// throughput: one quaternion per cycle while the response is not stalled, set by the fully
// pipelined divider, square root and three atan2 units; a four-entry queue decouples front
// and back; a stalled response freezes the back pipeline; the front keeps filling the queue
// reset: synchronous, active high; clears valids and queue, angle_in_degrees goes to 1
`default_nettype none
module quaternion_to_euler_angles_unit
   import qte_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_write_en,
   input  logic      csr_write_data,
   qte_req_if.sink   req_ch,
   qte_rsp_if.source rsp_ch
);

   // unit select register, 1 = degrees q7, 0 = radians q13
   logic degrees_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         degrees_ff <= 1'b1;
      end else if (csr_write_en) begin
         degrees_ff <= csr_write_data;
      end
   end

   // front: products, sums, zero and clamp classification
   qte_push_type     push;
   qte_q_status_type q_stat;
   qte_work_type     q_head;
   logic             pop;

   qte_front u_front (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .q_stat(q_stat),
      .push(push)
   );

   // short queue so each side stalls on its own
   qte_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .pop(pop),
      .head(q_head),
      .stat(q_stat)
   );

   // back: divide, root, atan2 and unit conversion, output register
   qte_back #(.STEPS(CORDIC_STEPS)) u_back (
      .clock(clock),
      .reset(reset),
      .angle_in_degrees(degrees_ff),
      .q_stat(q_stat),
      .q_head(q_head),
      .pop(pop),
      .rsp_ch(rsp_ch)
   );

endmodule
`default_nettype wire

// ----- verif/tb_quaternion_to_euler_angles_unit.sv -----
`timescale 1ns / 1ps
module tb_quaternion_to_euler_angles_unit;
   import qte_pkg::*;

   localparam int STEPS = 16;
   localparam int LATENCY = 69 + STEPS;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic signed [15:0] yaw;
      logic signed [14:0] pitch;
      logic signed [15:0] roll;
      logic err;
   } angles_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en = 1'b0;
   logic csr_write_data = 1'b0;

   qte_req_if req_ch ();
   qte_rsp_if rsp_ch ();

   quaternion_to_euler_angles_unit #(.CORDIC_STEPS(STEPS)) dut (
      .clock(clock),
      .reset(reset),
      .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state: its own copy of the unit setting
   logic in_degrees;
   angles_type expected_angles[$];
   int error_count = 0;
   int idle_cycles = 0;
   // idle percentages for each side; zero gives a stretch with no idling
   int req_idle_pct = 33;
   int rsp_stall_pct = 33;

   localparam longint ATAN_TAB[24] = '{
      421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
      8387925, 4194219, 2097141, 1048575, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024,
      512, 256, 128, 64};

   // arithmetic shift on longint already rounds toward minus infinity
   function automatic longint cordic_angle(longint y, longint x);
      longint z, dx, dy, t;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = 843314857;
         end else begin
            x = -y; y = t; z = -843314857;
         end
      end
      for (int i = 0; i < STEPS && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += ATAN_TAB[i];
         end else begin
            x -= dx; y += dy; z -= ATAN_TAB[i];
         end
      end
      return z;
   endfunction

   function automatic longint scale_angle(longint z, bit half);
      longint r, lim;
      if (in_degrees) begin
         r = (z * 3754936 + (64'sd1 <<< 37)) >>> 38;
         lim = half ? 11520 : 23040;
      end else begin
         r = (z + (64'sd1 <<< 15)) >>> 16;
         lim = half ? 12868 : 25736;
      end
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic angles_type euler_from_quat(logic signed [15:0] qr,
                                                  logic signed [15:0] qi,
                                                  logic signed [15:0] qj,
                                                  logic signed [15:0] qk);
      longint w, x, y, z, sw, sx, sy, sz, n, s, ts;
      longint unsigned mag, t, c;
      angles_type a;
      w = qr; x = qi; y = qj; z = qk;
      sw = w * w; sx = x * x; sy = y * y; sz = z * z;
      n = sw + sx + sy + sz;
      a = '0;
      if (n == 0) begin
         a.err = 1'b1;
         return a;
      end
      s = 2 * (y * w - x * z);
      mag = (s < 0) ? -s : s;
      if (mag > n) begin
         t = 64'd1 << 30;
         a.err = 1'b1;
      end else begin
         t = (mag << 30) / n;
      end
      c = int_sqrt((64'd1 << 60) - t * t);
      ts = (s < 0) ? -longint'(t) : longint'(t);
      a.yaw = 16'(scale_angle(cordic_angle(2 * (x * y + z * w), sw + sx - sy - sz), 1'b0));
      a.pitch = 15'(scale_angle(cordic_angle(ts, longint'(c)), 1'b1));
      a.roll = 16'(scale_angle(cordic_angle(2 * (y * z + x * w), sw - sx - sy + sz), 1'b0));
      return a;
   endfunction

   // send one quaternion, waiting for its transfer; valid is left high on return
   task automatic send_quat(logic signed [15:0] qr, logic signed [15:0] qi,
                            logic signed [15:0] qj, logic signed [15:0] qk);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.quat_real <= qr;
      req_ch.quat_i <= qi;
      req_ch.quat_j <= qj;
      req_ch.quat_k <= qk;
      expected_angles.push_back(euler_from_quat(qr, qi, qj, qk));
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // stop offering requests after the last transfer
   task automatic release_req();
      req_ch.valid <= 1'b0;
   endtask

   // waits for all expected responses and the pipeline to settle
   task automatic drain_pipeline();
      release_req();
      while (expected_angles.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic set_unit(logic degrees);
      drain_pipeline();
      csr_write_en <= 1'b1;
      csr_write_data <= degrees;
      in_degrees = degrees;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic random_quat();
      logic [15:0] r[4];
      for (int k = 0; k < 4; k++) begin
         case ($urandom_range(3))
            0: r[k] = 16'($urandom);
            1: r[k] = 16'($urandom_range(33)) - 16'd16; // near zero
            2: r[k] = $urandom_range(1) ? 16'h8000 : 16'h7fff;
            default: r[k] = 16'($urandom_range(32767)) - 16'd16384; // unit-ish range
         endcase
      end
      send_quat(r[0], r[1], r[2], r[3]);
   endtask

   task automatic test_directed_extremes();
      send_quat(0, 0, 0, 0);                          // all-zero quaternion
      send_quat(16384, 0, 0, 0);                      // identity
      send_quat(-16384, 0, 0, 0);
      send_quat(0, 16384, 0, 0);
      send_quat(0, 0, 16384, 0);
      send_quat(0, 0, 0, 16384);
      send_quat(11585, 0, 11585, 0);                  // pitch at +90
      send_quat(11585, 0, -11585, 0);                 // pitch at -90
      send_quat(-32768, -32768, -32768, -32768);
      send_quat(32767, 32767, 32767, 32767);
      send_quat(32767, -32768, 32767, -32768);
      send_quat(-32768, 32767, -32768, 32767);
      send_quat(1, 0, 0, 0);
      send_quat(0, 0, 0, -1);
      send_quat(0, 1, 1, 0);                          // roll vector on the negative x axis
      send_quat(-1, 1, -1, 1);
      send_quat(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
      send_quat(16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555);
   endtask

   task automatic test_random_mix(int count);
      for (int i = 0; i < count; i++) random_quat();
   endtask

   task automatic test_back_to_back(int count);
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      test_random_mix(count);
      req_idle_pct = 33;
      rsp_stall_pct = 33;
   endtask

   task automatic test_sender_pause();
      test_random_mix(20);
      release_req();
      while (expected_angles.size() != 0) @(posedge clock);
      test_random_mix(20);
   endtask

   // response checker: compare each transfer with the oldest expectation
   always @(posedge clock) begin
      angles_type want;
      if (!reset) begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_angles.size() == 0) begin
               $error("unexpected response transfer");
               error_count++;
            end else begin
               want = expected_angles.pop_front();
               if (rsp_ch.yaw_angle !== want.yaw) begin
                  $error("yaw_angle expected %0d actual %0d", want.yaw, rsp_ch.yaw_angle);
                  error_count++;
               end
               if (rsp_ch.pitch_angle !== want.pitch) begin
                  $error("pitch_angle expected %0d actual %0d", want.pitch,
                         rsp_ch.pitch_angle);
                  error_count++;
               end
               if (rsp_ch.roll_angle !== want.roll) begin
                  $error("roll_angle expected %0d actual %0d", want.roll, rsp_ch.roll_angle);
                  error_count++;
               end
               if (rsp_ch.range_error !== want.err) begin
                  $error("range_error expected %0d actual %0d", want.err,
                         rsp_ch.range_error);
                  error_count++;
               end
            end
         end
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.quat_real = '0;
      req_ch.quat_i = '0;
      req_ch.quat_j = '0;
      req_ch.quat_k = '0;
      rsp_ch.ready = 1'b0;
      in_degrees = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();          // reset setting: degrees
      set_unit(1'b0);
      test_directed_extremes();          // radians
      test_random_mix(250);
      set_unit(1'b1);
      test_random_mix(250);
      test_back_to_back(150);
      test_sender_pause();
      set_unit(1'b0);
      test_random_mix(120);
      drain_pipeline();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
